// ----- rtl/vna_pkg.sv -----
// Package for the vertex normal accumulator: sizes, op codes, shared types.
// No dependencies.
package vna_pkg;
  localparam int MaxVertices = 1024;
  localparam int IdxW = 10;
  localparam int SumW = 24;
  localparam int PosW = 24;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // request/response between sequencer and normalizer
  typedef struct packed {
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] vz;
  } vec_t;

  typedef struct packed {
    logic        ok;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } unit_t;
endpackage

// ----- rtl/vna_unitize.sv -----
// Iterative vector normalizer: leading-one scale, bit-serial sqrt, serial divides.
// Depends on vna_pkg.
module vna_unitize (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  vna_pkg::vec_t  vin,
  output logic           done,
  output vna_pkg::unit_t res
);
  import vna_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [63:0] mag [3];
  logic [2:0]  neg;
  logic [1:0]  comp;
  logic [63:0] s, r, bitv;
  logic [47:0] num, quo;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic [15:0] q [3];

  logic [63:0] m01, mmax;
  logic [63:0] rb;
  logic [32:0] rem_sh;
  logic [29:0] sq_op;
  logic [59:0] sq_prod;
  logic [63:0] sq_term;
  logic [16:0] rnd;

  // magnitudes are below 2^30 once scaled, so a 30-bit square suffices
  always_comb begin
    m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mmax = (m01 > mag[2]) ? m01 : mag[2];
    rb   = r + bitv;
    rem_sh = {rem[31:0], num[47]};
    sq_op = mag[comp][29:0];
    sq_prod = sq_op * sq_op;
    sq_term = {4'd0, sq_prod};
    rnd = quo[16:0];
  end

  // done strobe: zero vector found, or last component written
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ((state == S_NORM) && (mmax == 64'd0)) ||
                 ((state == S_OUT) && (comp == 2'd2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            neg <= {vin.vz[63], vin.vy[63], vin.vx[63]};
            mag[0] <= vin.vx[63] ? 64'(-vin.vx) : vin.vx;
            mag[1] <= vin.vy[63] ? 64'(-vin.vy) : vin.vy;
            mag[2] <= vin.vz[63] ? 64'(-vin.vz) : vin.vz;
            state <= S_NORM;
          end
        end
        // shift one bit a cycle until max lies in [2^29, 2^30)
        S_NORM: begin
          if (mmax == 64'd0) begin
            res <= '0;
            state <= S_IDLE;
          end else if (mmax >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (mmax < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            s <= '0;
            comp <= 2'd0;
            state <= S_SQ;
          end
        end
        // sum of squares, one product a cycle
        S_SQ: begin
          s <= s + sq_term;
          if (comp == 2'd2) begin
            r <= '0;
            bitv <= 64'd1 << 62;
            state <= S_SQRT;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_SQRT: begin
          if (bitv == 64'd0) begin
            comp <= 2'd0;
            num <= {mag[0][32:0], 15'd0} + {16'd0, r[32:1]};
            rem <= '0;
            cnt <= '0;
            state <= S_DIV;
          end else begin
            if (s >= rb) begin
              s <= s - rb;
              r <= (r >> 1) + bitv;
            end else begin
              r <= r >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          if (rem_sh >= r[32:0]) begin
            rem <= rem_sh - r[32:0];
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[46:0], 1'b0};
          end
          num <= {num[46:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd47) state <= S_OUT;
        end
        S_OUT: begin
          if (neg[comp]) q[comp] <= (rnd >= 17'd32768) ? 16'h8000 : 16'(-rnd);
          else q[comp] <= (rnd >= 17'd32767) ? 16'h7fff : rnd[15:0];
          if (comp == 2'd2) begin
            res.ok <= 1'b1;
            res.qx <= q[0];
            res.qy <= q[1];
            res.qz <= (neg[2]) ? ((rnd >= 17'd32768) ? 16'h8000 : 16'(-rnd))
                              : ((rnd >= 17'd32767) ? 16'h7fff : rnd[15:0]);
            state <= S_IDLE;
          end else begin
            comp <= comp + 2'd1;
            num <= {mag[comp + 2'd1][32:0], 15'd0} + {16'd0, r[32:1]};
            rem <= '0;
            cnt <= '0;
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/vertex_normal_accumulator.sv -----
// Top level: vertex stores, accumulators and the op sequencer.
// Depends on vna_pkg and vna_unitize.
//
// One command is taken when start is high and busy low. After reset the block
// clears every accumulator slot, with busy high. A load is taken straight from
// idle and busy stays low. A read or an add waits on the shared normalizer: a
// one-bit-a-cycle scaling shift, squaring, a bit-serial square root and three
// serial divides. A degenerate add, or a read of a zero accumulator, ends as
// soon as the normalizer finds the zero vector. The result of a read shows for
// one cycle with valid; the receiver cannot stall, so nothing is buffered. A
// position is undefined until its slot is loaded.
module vertex_normal_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [9:0]  vertex_index,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [9:0]  corner_a,
  input  logic [9:0]  corner_b,
  input  logic [9:0]  corner_c,
  output logic        valid,
  output logic [9:0]  which_vertex,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic        no_normal
);
  import vna_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDP   = 4'd1;
  localparam logic [3:0] S_LATP  = 4'd2;
  localparam logic [3:0] S_EDGE  = 4'd3;
  localparam logic [3:0] S_CROSS = 4'd4;
  localparam logic [3:0] S_NORMW = 4'd5;
  localparam logic [3:0] S_ACCR  = 4'd6;
  localparam logic [3:0] S_ACCW  = 4'd7;
  localparam logic [3:0] S_RDS   = 4'd8;
  localparam logic [3:0] S_RDSL  = 4'd9;
  localparam logic [3:0] S_CLR   = 4'd10;

  logic [3*PosW-1:0] pos_mem [MaxVertices];
  logic [3*SumW-1:0] sum_mem [MaxVertices];
  logic [3*PosW-1:0] pos_rd;
  logic [3*SumW-1:0] sum_rd;
  logic [IdxW-1:0]   paddr, saddr;
  logic [IdxW-1:0]   clr_addr;

  logic [3:0]  state;
  logic [1:0]  cur_op;
  logic [IdxW-1:0] idx, ka [3];
  logic [1:0]  k;
  logic signed [24:0] pa [3];
  logic signed [24:0] e1 [3], e2 [3];
  logic signed [63:0] n [3];
  logic [2:0]  step;
  logic        ugo, udone;
  vec_t        uin;
  unit_t       ures, face;

  function automatic logic [SumW-1:0] sat(input logic [SumW-1:0] a,
                                          input logic signed [15:0] d);
    logic signed [SumW:0] t;
    t = $signed({a[SumW-1], a}) + (SumW+1)'(d);
    if (t[SumW] != t[SumW-1]) sat = t[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                             : {1'b0, {(SumW-1){1'b1}}};
    else sat = t[SumW-1:0];
  endfunction

  // position memory
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && op == OP_LOAD)
      pos_mem[vertex_index] <= {pos_x, pos_y, pos_z};
    pos_rd <= pos_mem[paddr];
  end

  // accumulator memory; cleared after reset, loads clear one slot
  always_ff @(posedge clk) begin
    if (state == S_CLR)
      sum_mem[clr_addr] <= '0;
    else if (state == S_IDLE && start && op == OP_LOAD)
      sum_mem[vertex_index] <= '0;
    else if (state == S_ACCW) begin
      sum_mem[ka[k]] <= {sat(sum_rd[3*SumW-1:2*SumW], face.qx),
                         sat(sum_rd[2*SumW-1:SumW], face.qy),
                         sat(sum_rd[SumW-1:0], face.qz)};
    end
    sum_rd <= sum_mem[saddr];
  end

  assign paddr = ka[k];
  assign saddr = (state == S_RDS) ? idx : ka[k];
  assign busy = (state != S_IDLE);

  // cross product terms: products one at a time through a shared multiplier
  logic signed [24:0] ma, mb;
  logic signed [49:0] prod;
  always_comb begin
    unique case (step)
      3'd0: begin ma = e1[1]; mb = e2[2]; end
      3'd1: begin ma = e1[2]; mb = e2[1]; end
      3'd2: begin ma = e1[2]; mb = e2[0]; end
      3'd3: begin ma = e1[0]; mb = e2[2]; end
      3'd4: begin ma = e1[0]; mb = e2[1]; end
      3'd5: begin ma = e1[1]; mb = e2[0]; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  vna_unitize u_unit (.clk(clk), .rst(rst), .go(ugo), .vin(uin), .done(udone), .res(ures));

  // one-cycle strobes: result transfer and normalizer kick
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ugo <= 1'b0;
    end else begin
      valid <= (state == S_NORMW) && udone && (cur_op == OP_READ);
      ugo <= ((state == S_CROSS) && (step == 3'd6)) || (state == S_RDSL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        // sweep every accumulator slot to zero
        S_CLR: begin
          clr_addr <= clr_addr + IdxW'(1);
          if (clr_addr == IdxW'(MaxVertices - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cur_op <= op;
            idx <= vertex_index;
            ka[0] <= corner_a; ka[1] <= corner_b; ka[2] <= corner_c;
            k <= 2'd0;
            if (op == OP_ADD) state <= S_RDP;
            else if (op == OP_READ) state <= S_RDS;
          end
        end
        S_RDP: state <= S_LATP;
        S_LATP: begin
          if (k == 2'd0) begin
            pa[0] <= 25'($signed(pos_rd[71:48]));
            pa[1] <= 25'($signed(pos_rd[47:24]));
            pa[2] <= 25'($signed(pos_rd[23:0]));
          end else if (k == 2'd1) begin
            e1[0] <= 25'($signed(pos_rd[71:48])) - pa[0];
            e1[1] <= 25'($signed(pos_rd[47:24])) - pa[1];
            e1[2] <= 25'($signed(pos_rd[23:0])) - pa[2];
          end else begin
            e2[0] <= 25'($signed(pos_rd[71:48])) - pa[0];
            e2[1] <= 25'($signed(pos_rd[47:24])) - pa[1];
            e2[2] <= 25'($signed(pos_rd[23:0])) - pa[2];
          end
          if (k == 2'd2) begin
            step <= 3'd0;
            state <= S_CROSS;
          end else begin
            k <= k + 2'd1;
            state <= S_RDP;
          end
        end
        S_CROSS: begin
          unique case (step)
            3'd0: n[0] <= 64'(prod);
            3'd1: n[0] <= n[0] - 64'(prod);
            3'd2: n[1] <= 64'(prod);
            3'd3: n[1] <= n[1] - 64'(prod);
            3'd4: n[2] <= 64'(prod);
            3'd5: n[2] <= n[2] - 64'(prod);
            default: ;
          endcase
          step <= step + 3'd1;
          if (step == 3'd6) begin
            uin <= '{vx: n[0], vy: n[1], vz: n[2]};
            state <= S_NORMW;
          end
        end
        S_NORMW: begin
          if (udone) begin
            if (cur_op == OP_READ) begin
              which_vertex <= idx;
              norm_x <= ures.qx; norm_y <= ures.qy; norm_z <= ures.qz;
              no_normal <= !ures.ok;
              state <= S_IDLE;
            end else if (ures.ok) begin
              face <= ures;
              k <= 2'd0;
              state <= S_ACCR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ACCR: state <= S_EDGE;
        S_EDGE: state <= S_ACCW;
        S_ACCW: begin
          if (k == 2'd2) state <= S_IDLE;
          else begin
            k <= k + 2'd1;
            state <= S_ACCR;
          end
        end
        S_RDS: state <= S_RDSL;
        S_RDSL: begin
          uin <= '{vx: 64'($signed(sum_rd[3*SumW-1:2*SumW])),
                   vy: 64'($signed(sum_rd[2*SumW-1:SumW])),
                   vz: 64'($signed(sum_rd[SumW-1:0]))};
          state <= S_NORMW;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sim/vertex_normal_accumulator_tb.sv -----
// Self-checking testbench for vertex_normal_accumulator: slot fill, directed table, random traffic, saturation.
// Depends on vna_pkg and the RTL; predicts each vertex normal read with a local fixed-point model or a table entry.
module vertex_normal_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [9:0]  idx;
    int          px, py, pz;
    logic [9:0]  ca, cb, cc;
    bit          typed;
    shortint     ex, ey, ez;
    bit          enn;
  } cmd_t;

  typedef struct {
    logic [9:0] which;
    shortint    nx, ny, nz;
    bit         nn;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = OP_LOAD;
  logic [9:0] vertex_index = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [9:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic valid;
  logic [9:0] which_vertex;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic no_normal;

  vertex_normal_accumulator dut (.*);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of positions and per-vertex normal sums
  int pos_mem_x[MaxVertices], pos_mem_y[MaxVertices], pos_mem_z[MaxVertices];
  int acc_x[MaxVertices], acc_y[MaxVertices], acc_z[MaxVertices];
  normal_t pending_normals[$];
  int errors = 0;
  int gap_pct = 0;

  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale to [2^29, 2^30), divide by length, round half up, saturate
  function automatic bit to_unit(input longint vx, vy, vz,
                                 output shortint qx, qy, qz);
    longint unsigned mag[3], m, s, len, r;
    bit neg[3];
    longint v[3];
    int b;
    shortint q[3];
    v[0] = vx; v[1] = vy; v[2] = vz;
    m = 0;
    b = 0;
    qx = 0; qy = 0; qz = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return 1'b0;
    while (b < 64 && (m >> b) != 0) b++;
    for (int i = 0; i < 3; i++)
      mag[i] = (b > 30) ? mag[i] >> (b - 30) : mag[i] << (30 - b);
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = floor_root(s);
    for (int i = 0; i < 3; i++) begin
      r = (mag[i] * 32768 + len / 2) / len;
      if (neg[i]) q[i] = (r >= 32768) ? -32768 : -shortint'(r);
      else q[i] = (r >= 32767) ? 32767 : shortint'(r);
    end
    qx = q[0]; qy = q[1]; qz = q[2];
    return 1'b1;
  endfunction

  function automatic int sum_sat(int a, int d);
    int t;
    t = a + d;
    if (t > (1 << (SumW - 1)) - 1) t = (1 << (SumW - 1)) - 1;
    if (t < -(1 << (SumW - 1))) t = -(1 << (SumW - 1));
    return t;
  endfunction

  // update local state for one accepted command, queue the read result
  task automatic predict_normal(input cmd_t c);
    longint e1[3], e2[3];
    longint n0, n1, n2;
    shortint qx, qy, qz;
    int k[3];
    normal_t res;
    case (c.op)
      OP_LOAD: begin
        pos_mem_x[c.idx] = c.px; pos_mem_y[c.idx] = c.py; pos_mem_z[c.idx] = c.pz;
        acc_x[c.idx] = 0; acc_y[c.idx] = 0; acc_z[c.idx] = 0;
      end
      OP_ADD: begin
        e1[0] = pos_mem_x[c.cb] - longint'(pos_mem_x[c.ca]);
        e1[1] = pos_mem_y[c.cb] - longint'(pos_mem_y[c.ca]);
        e1[2] = pos_mem_z[c.cb] - longint'(pos_mem_z[c.ca]);
        e2[0] = pos_mem_x[c.cc] - longint'(pos_mem_x[c.ca]);
        e2[1] = pos_mem_y[c.cc] - longint'(pos_mem_y[c.ca]);
        e2[2] = pos_mem_z[c.cc] - longint'(pos_mem_z[c.ca]);
        n0 = e1[1] * e2[2] - e1[2] * e2[1];
        n1 = e1[2] * e2[0] - e1[0] * e2[2];
        n2 = e1[0] * e2[1] - e1[1] * e2[0];
        if (to_unit(n0, n1, n2, qx, qy, qz)) begin
          k[0] = c.ca; k[1] = c.cb; k[2] = c.cc;
          foreach (k[i]) begin
            acc_x[k[i]] = sum_sat(acc_x[k[i]], qx);
            acc_y[k[i]] = sum_sat(acc_y[k[i]], qy);
            acc_z[k[i]] = sum_sat(acc_z[k[i]], qz);
          end
        end
      end
      OP_READ: begin
        res.which = c.idx;
        res.nn = !to_unit(acc_x[c.idx], acc_y[c.idx], acc_z[c.idx], qx, qy, qz);
        res.nx = qx; res.ny = qy; res.nz = qz;
        if (c.typed) begin
          res.nx = c.ex; res.ny = c.ey; res.nz = c.ez; res.nn = c.enn;
        end
        pending_normals = {pending_normals, res};
      end
      default: ;
    endcase
  endtask

  // hold the command until the block takes it
  task automatic issue(input cmd_t c);
    op <= c.op;
    vertex_index <= c.idx;
    pos_x <= c.px[23:0]; pos_y <= c.py[23:0]; pos_z <= c.pz[23:0];
    corner_a <= c.ca; corner_b <= c.cb; corner_c <= c.cc;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_normal(c);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic cmd_t mk(logic [1:0] o, int i, int x, int y, int z,
                              int a, int b, int cc);
    cmd_t c;
    c = '{o, i[9:0], x, y, z, a[9:0], b[9:0], cc[9:0], 1'b0, 0, 0, 0, 1'b0};
    return c;
  endfunction

  function automatic cmd_t mk_read(int i, int x, int y, int z, bit nn);
    cmd_t c;
    c = mk(OP_READ, i, 0, 0, 0, 0, 0, 0);
    c.typed = 1'b1;
    c.ex = x; c.ey = y; c.ez = z; c.enn = nn;
    return c;
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 8388607 : -8388608;
      1: return int'($urandom_range(2000)) - 1000;
      default: return $signed($urandom() << 8) >>> 8;
    endcase
  endfunction

  // mostly valid mesh traffic around a local neighborhood, some noise
  function automatic cmd_t rand_cmd();
    int base, sel;
    cmd_t c;
    base = $urandom_range(1023);
    sel = $urandom_range(99);
    if (sel < 25)
      c = mk(OP_LOAD, $urandom_range(1023), rand_pos(), rand_pos(), rand_pos(), 0, 0, 0);
    else if (sel < 65)
      c = mk(OP_ADD, 0, 0, 0, 0, (base + $urandom_range(8)) % 1024,
             (base + $urandom_range(8)) % 1024, (base + $urandom_range(8)) % 1024);
    else if (sel < 70)
      c = mk(OP_ADD, 0, 0, 0, 0, $urandom_range(1023), $urandom_range(1023),
             $urandom_range(1023));
    else if (sel < 96)
      c = mk(OP_READ, $urandom_range(1023), 0, 0, 0, 0, 0, 0);
    else
      c = mk(OP_UNUSED, $urandom_range(1023), rand_pos(), rand_pos(), rand_pos(),
             $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
    return c;
  endfunction

  // directed table: axis triangles, orientation flip, extremes, degenerate, unused op
  cmd_t directed[] = '{
    mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0),
    mk(OP_LOAD, 1, 65536, 0, 0, 0, 0, 0),
    mk(OP_LOAD, 2, 0, 65536, 0, 0, 0, 0),
    mk_read(0, 0, 0, 0, 1'b1),
    mk(OP_ADD, 0, 0, 0, 0, 0, 1, 2),
    mk_read(0, 0, 0, 32767, 1'b0),
    mk(OP_ADD, 0, 0, 0, 0, 0, 2, 1),
    mk_read(1, 0, 0, -32768, 1'b0),
    mk(OP_ADD, 0, 0, 0, 0, 0, 2, 1),
    mk_read(2, 0, 0, -32768, 1'b0),
    mk(OP_LOAD, 1023, 8388607, -8388608, 8388607, 0, 0, 0),
    mk(OP_LOAD, 1022, -8388608, 8388607, -8388608, 0, 0, 0),
    mk(OP_LOAD, 1021, 8388607, 8388607, -8388608, 0, 0, 0),
    mk(OP_ADD, 0, 0, 0, 0, 1023, 1022, 1021),
    mk(OP_READ, 1023, 0, 0, 0, 0, 0, 0),
    mk(OP_ADD, 0, 0, 0, 0, 1023, 1023, 1022),
    mk(OP_LOAD, 5, 131072, 131072, 131072, 0, 0, 0),
    mk(OP_LOAD, 6, 262144, 262144, 262144, 0, 0, 0),
    mk(OP_ADD, 0, 0, 0, 0, 0, 5, 6),
    mk_read(5, 0, 0, 0, 1'b1),
    mk(OP_UNUSED, 5, -1, -1, -1, 1023, 1023, 1023),
    mk(OP_READ, 1022, 0, 0, 0, 0, 0, 0),
    mk(OP_READ, 1021, 0, 0, 0, 0, 0, 0)
  };

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    normal_t e;
    if (!rst && valid) begin
      if (pending_normals.size() == 0) begin
        report("unexpected result, vertex", which_vertex, -1);
      end else begin
        e = pending_normals.pop_front();
        if (which_vertex !== e.which) report("which_vertex", which_vertex, e.which);
        if (norm_x !== e.nx) report("norm_x", norm_x, e.nx);
        if (norm_y !== e.ny) report("norm_y", norm_y, e.ny);
        if (norm_z !== e.nz) report("norm_z", norm_z, e.nz);
        if (no_normal !== e.nn) report("no_normal", no_normal, e.nn);
      end
    end
  end

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // fill every slot so no position is read before it is written
    for (int i = 0; i < MaxVertices; i++)
      issue(mk(OP_LOAD, i, rand_pos(), rand_pos(), rand_pos(), 0, 0, 0));
    foreach (directed[i]) issue(directed[i]);
    // random phases: light gaps, heavy gaps, back to back
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 14 : (ph == 1) ? 83 : 0;
      for (int n = 0; n < 150; n++) issue(rand_cmd());
      start <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clk);
      @(posedge clk);
    end
    // accumulator saturation: one small triangle added many times
    issue(mk(OP_LOAD, 700, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_LOAD, 701, 0, 0, 1000, 0, 0, 0));
    issue(mk(OP_LOAD, 702, 1000, 0, 0, 0, 0, 0));
    for (int n = 0; n < 270; n++) begin
      issue(mk(OP_ADD, 0, 0, 0, 0, 700, 701, 702));
      if (n % 64 == 0) issue(mk(OP_READ, 700, 0, 0, 0, 0, 0, 0));
    end
    issue(mk_read(701, 0, 32767, 0, 1'b0));
    start <= 1'b0;
    waited = 0;
    while (pending_normals.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
